// File: rtl/mtp_pkg.sv
// Package for the MT19937 generator core: table geometry, generator constants,
// action codes, controller state type and the tempering function.
// No dependencies.
package mtp_pkg;

  localparam int TABLE_DEPTH  = 624;
  localparam int TWIST_OFFSET = 397;
  localparam int IDX_W        = 10;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [IDX_W-1:0] FAR_SPLIT = IDX_W'(TABLE_DEPTH - TWIST_OFFSET);
  localparam logic [IDX_W-1:0] FAR_UP = IDX_W'(TWIST_OFFSET);
  localparam logic [IDX_W-1:0] FAR_DOWN = IDX_W'(TABLE_DEPTH - TWIST_OFFSET);

  localparam logic [31:0] MATRIX_A   = 32'h9908_b0df;
  localparam logic [31:0] SEED_MULT  = 32'h6c07_8965;
  localparam logic [31:0] TEMPER_B   = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C   = 32'hefc6_0000;
  localparam logic [31:0] UPPER_BIT  = 32'h8000_0000;
  localparam logic [31:0] LOWER_BITS = 32'h7fff_ffff;

  typedef enum logic [1:0] {
    ACT_SEED   = 2'd0,
    ACT_DRAW32 = 2'd1,
    ACT_DRAW31 = 2'd2,
    ACT_DRAW64 = 2'd3
  } action_t;

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b00_0000_0001,
    ST_SD_MUL   = 10'b00_0000_0010,
    ST_SD_ADD   = 10'b00_0000_0100,
    ST_TW_START = 10'b00_0000_1000,
    ST_TW_CUR   = 10'b00_0001_0000,
    ST_TW_FAR   = 10'b00_0010_0000,
    ST_TW_WR    = 10'b00_0100_0000,
    ST_DR_RD    = 10'b00_1000_0000,
    ST_DR_TMP   = 10'b01_0000_0000,
    ST_DR_OUT   = 10'b10_0000_0000
  } state_t;

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] v;
    v = w ^ (w >> 11);
    v = v ^ ((v << 7) & TEMPER_B);
    v = v ^ ((v << 15) & TEMPER_C);
    v = v ^ (v >> 18);
    return v;
  endfunction

endpackage

// File: rtl/mersenne_twister_prng_core.sv
// MT19937 generator core: 624-word state table in a synchronous RAM, seeding,
// twist and tempering sequenced by one controller.
// Depends on mtp_pkg.
//
//  channel | dir | tdata fields (low bit up)            | transfer
//  in_     | in  | action[1:0], seed_value[33:2], pad   | in_tvalid & in_tready
//  out_    | out | random_value[63:0]                   | out_tvalid & out_tready
//
// One item at a time; in_tready is high only while idle. A seed runs one
// multiply stage and one write per table word. A draw first runs a twist
// when the read index is at zero; a 64-bit draw runs the word sequence twice.
// The twist loop is set by the single RAM read port. Synchronous reset clears
// the controller, read index and output valid. A finished result waits in the
// output register; the core stalls before loading the next one only while
// that register is full and out_tready is low.
module mersenne_twister_prng_core
  import mtp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // action[1:0], seed_value[33:2], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // random_value[63:0]
);

  logic [31:0] mem [TABLE_DEPTH];
  logic [31:0] rdata_r;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic [31:0] wr_data;
  logic wr_en;

  state_t state_r, state_nxt;
  logic [IDX_W-1:0] ctr_r, ctr_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic second_r, second_nxt;
  logic [31:0] p_r, p_nxt;
  logic [31:0] mul_r, mul_nxt;
  logic [31:0] cur_r, cur_nxt;
  logic [31:0] nxt_r, nxt_nxt;
  logic [31:0] hi_r, hi_nxt;
  logic [63:0] res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [63:0] out_data_r, out_data_nxt;

  logic in_xfer;
  logic [1:0] in_action;
  logic [31:0] in_seed;
  logic [31:0] seed_word;
  logic [31:0] twist_y;
  logic [31:0] twist_v;
  logic [31:0] tempered;
  logic [IDX_W-1:0] far_addr;
  logic [IDX_W-1:0] idx_inc;

  assign in_action = in_tdata[1:0];
  assign in_seed   = in_tdata[33:2];
  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign seed_word = mul_r + {{(32-IDX_W){1'b0}}, ctr_r};
  assign twist_y   = (cur_r & UPPER_BIT) | (nxt_r & LOWER_BITS);
  assign twist_v   = rdata_r ^ (twist_y >> 1) ^ (twist_y[0] ? MATRIX_A : 32'd0);
  assign tempered  = temper(rdata_r);
  assign far_addr  = (ctr_r < FAR_SPLIT) ? (ctr_r + FAR_UP) : (ctr_r - FAR_DOWN);
  assign idx_inc   = (rd_idx_r == IDX_LAST) ? '0 : (rd_idx_r + IDX_W'(1));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    ctr_nxt       = ctr_r;
    rd_idx_nxt    = rd_idx_r;
    kind_nxt      = kind_r;
    second_nxt    = second_r;
    p_nxt         = p_r;
    mul_nxt       = mul_r;
    cur_nxt       = cur_r;
    nxt_nxt       = nxt_r;
    hi_nxt        = hi_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    rd_addr       = rd_idx_r;
    wr_addr       = ctr_r;
    wr_data       = seed_word;
    wr_en         = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          kind_nxt   = in_action;
          second_nxt = 1'b0;
          if (in_action == ACT_SEED) begin
            wr_addr    = '0;
            wr_data    = in_seed;
            wr_en      = 1'b1;
            p_nxt      = in_seed;
            ctr_nxt    = IDX_W'(1);
            rd_idx_nxt = '0;
            state_nxt  = ST_SD_MUL;
          end else if (rd_idx_r == '0) begin
            state_nxt = ST_TW_START;
          end else begin
            state_nxt = ST_DR_RD;
          end
        end
      end
      ST_SD_MUL: begin
        mul_nxt   = SEED_MULT * (p_r ^ (p_r >> 30));
        state_nxt = ST_SD_ADD;
      end
      ST_SD_ADD: begin
        wr_en = 1'b1;
        p_nxt = seed_word;
        if (ctr_r == IDX_LAST) begin
          state_nxt = ST_IDLE;
        end else begin
          ctr_nxt   = ctr_r + IDX_W'(1);
          state_nxt = ST_SD_MUL;
        end
      end
      ST_TW_START: begin
        rd_addr   = '0;
        ctr_nxt   = '0;
        state_nxt = ST_TW_CUR;
      end
      ST_TW_CUR: begin
        cur_nxt   = rdata_r;
        rd_addr   = IDX_W'(1);
        state_nxt = ST_TW_FAR;
      end
      ST_TW_FAR: begin
        nxt_nxt   = rdata_r;
        rd_addr   = far_addr;
        state_nxt = ST_TW_WR;
      end
      ST_TW_WR: begin
        wr_en   = 1'b1;
        wr_data = twist_v;
        cur_nxt = nxt_r;
        if (ctr_r == IDX_LAST) begin
          state_nxt = ST_DR_RD;
        end else begin
          ctr_nxt   = ctr_r + IDX_W'(1);
          rd_addr   = (ctr_r == IDX_LAST - IDX_W'(1)) ? '0 : (ctr_r + IDX_W'(2));
          state_nxt = ST_TW_FAR;
        end
      end
      ST_DR_RD: begin
        rd_addr   = rd_idx_r;
        state_nxt = ST_DR_TMP;
      end
      ST_DR_TMP: begin
        rd_idx_nxt = idx_inc;
        if (kind_r == ACT_DRAW64 && !second_r) begin
          hi_nxt     = tempered;
          second_nxt = 1'b1;
          state_nxt  = (idx_inc == '0) ? ST_TW_START : ST_DR_RD;
        end else begin
          unique case (kind_r)
            ACT_DRAW64: res_nxt = {hi_r, tempered};
            ACT_DRAW31: res_nxt = {32'd0, tempered & LOWER_BITS};
            default:    res_nxt = {32'd0, tempered};
          endcase
          state_nxt = ST_DR_OUT;
        end
      end
      ST_DR_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
      ctr_r       <= '0;
      kind_r      <= ACT_SEED;
      second_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
      ctr_r       <= ctr_nxt;
      kind_r      <= kind_nxt;
      second_r    <= second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r        <= p_nxt;
    mul_r      <= mul_nxt;
    cur_r      <= cur_nxt;
    nxt_r      <= nxt_nxt;
    hi_r       <= hi_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
